@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue core.
// ----------------------------------------------------------------------------
package spq_pkg;

    // depth must be a power of two
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int PRI_W   = 8;
    localparam int TAG_W   = 32;
    localparam int ENTRY_W = PRI_W + TAG_W;
    localparam int CFG_W   = 7;
    localparam int OCC_W   = 7;
    localparam int CAP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CFG_RESET = 64;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_POP    = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_POPPED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_INS_CMP,
        S_INS_PLACE,
        S_RESPOND
    } state_t;

    typedef struct packed {
        logic    latch;
        logic    ins_start;
        logic    shift;
        logic    place;
        logic    pop;
        logic    load_out;
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_pop;
        logic empty;
        logic full;
        logic shift_ok;
        logic j_is_one;
        logic out_free;
    } dp_stat_t;

endpackage

@@ sv/spq_ctrl.sv @@
// ----------------------------------------------------------------------------
// spq_ctrl
// Request sequencer: decodes a request, walks the insert shift loop and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= ST_INSERTED;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (stat.is_pop) begin
                    code_next  = stat.empty ? ST_EMPTY : ST_POPPED;
                    state_next = S_RESPOND;
                end else if (stat.full) begin
                    code_next  = ST_FULL;
                    state_next = S_RESPOND;
                end else begin
                    code_next  = ST_INSERTED;
                    state_next = stat.empty ? S_INS_PLACE : S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (!stat.shift_ok) state_next = S_RESPOND;
                else if (stat.j_is_one) state_next = S_INS_PLACE;
            end
            S_INS_PLACE: begin
                state_next = S_RESPOND;
            end
            S_RESPOND: begin
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        cmd.code = code_reg;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready  = 1'b1;
                cmd.latch = s_tvalid;
            end
            S_DECIDE: begin
                cmd.pop       = stat.is_pop && !stat.empty;
                cmd.ins_start = !stat.is_pop && !stat.full && !stat.empty;
            end
            S_INS_CMP: begin
                cmd.shift = stat.shift_ok;
                cmd.place = !stat.shift_ok;
            end
            S_INS_PLACE: begin
                cmd.place = 1'b1;
            end
            S_RESPOND: begin
                cmd.load_out = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

@@ sv/spq_dp.sv @@
// ----------------------------------------------------------------------------
// spq_dp
// Datapath: circular entry store, head and count, insert shift pointer,
// capacity register and the result register.
// ----------------------------------------------------------------------------
module spq_dp
    import spq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic [ENTRY_W-1:0]       s_tdata,
    input  logic                     s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [((ENTRY_W+OCC_W+7)/8)*8-1:0] m_tdata,
    output logic [1:0]               m_tuser,
    input  logic                     cfg_valid,
    input  logic [CFG_W-1:0]         cfg_data,
    input  ctrl_cmd_t                cmd,
    output dp_stat_t                 stat
);

    localparam int OUT_W = ((ENTRY_W + OCC_W + 7) / 8) * 8;

    logic [ENTRY_W-1:0] mem [DEPTH];

    logic               req_reg;
    logic [PRI_W-1:0]   pri_reg;
    logic [TAG_W-1:0]   tag_reg;
    logic [ADDR_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   j_reg, j_next;
    logic [CFG_W-1:0]   max_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    status_t            out_status_reg;
    logic [PRI_W-1:0]   out_pri_reg;
    logic [TAG_W-1:0]   out_tag_reg;
    logic [OCC_W-1:0]   out_occ_reg;

    logic [CAP_W-1:0]   cap;
    logic [CNT_W-1:0]   j_m1, j_m2, cnt_m1;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_en, rd_en;

    // effective capacity clamped to 1..DEPTH
    always_comb begin
        if (max_reg == '0) cap = CAP_W'(1);
        else if (CAP_W'(max_reg) > CAP_W'(DEPTH)) cap = CAP_W'(DEPTH);
        else cap = CAP_W'(max_reg);
    end

    assign j_m1   = j_reg - CNT_W'(1);
    assign j_m2   = j_reg - CNT_W'(2);
    assign cnt_m1 = count_reg - CNT_W'(1);

    assign stat.is_pop   = (req_reg == REQ_POP);
    assign stat.empty    = (count_reg == '0);
    assign stat.full     = (CAP_W'(count_reg) >= cap);
    assign stat.shift_ok = (rd_data_reg[PRI_W-1:0] < pri_reg);
    assign stat.j_is_one = (j_reg == CNT_W'(1));
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // memory access
    always_comb begin
        wr_en   = cmd.shift || cmd.place;
        wr_addr = head_reg + j_reg[ADDR_W-1:0];
        wr_data = cmd.shift ? rd_data_reg : {tag_reg, pri_reg};
        rd_en   = cmd.pop || cmd.ins_start || cmd.shift;
        if (cmd.pop) rd_addr = head_reg;
        else if (cmd.ins_start) rd_addr = head_reg + cnt_m1[ADDR_W-1:0];
        else rd_addr = head_reg + j_m2[ADDR_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_data_reg <= mem[rd_addr];
    end

    // pointers and count
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        j_next     = j_reg;
        if (cmd.pop) begin
            head_next  = head_reg + ADDR_W'(1);
            count_next = cnt_m1;
        end
        if (cmd.ins_start) j_next = count_reg;
        if (cmd.shift) j_next = j_m1;
        if (cmd.place) count_next = count_reg + CNT_W'(1);
    end

    // a placement from the decide state with an empty queue uses slot zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
            max_reg   <= CFG_W'(CFG_RESET);
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_valid) max_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            req_reg <= s_tuser;
            pri_reg <= s_tdata[PRI_W-1:0];
            tag_reg <= s_tdata[ENTRY_W-1:PRI_W];
            j_reg   <= '0;
        end else begin
            j_reg   <= j_next;
        end
    end

    // result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (cmd.load_out) m_tvalid_next = 1'b1;
        else if (m_tready) m_tvalid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) m_tvalid_reg <= 1'b0;
        else m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_status_reg <= cmd.code;
            out_occ_reg    <= OCC_W'(count_reg);
            if (cmd.code == ST_POPPED) begin
                out_pri_reg <= rd_data_reg[PRI_W-1:0];
                out_tag_reg <= rd_data_reg[ENTRY_W-1:PRI_W];
            end else begin
                out_pri_reg <= '0;
                out_tag_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = OUT_W'({out_occ_reg, out_tag_reg, out_pri_reg});

endmodule

@@ sv/sorted_priority_queue_core.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Bounded max-priority queue held sorted in a circular entry memory.
// ----------------------------------------------------------------------------
// s_ channel carries requests: s_tuser 0 inserts the priority and tag in
// s_tdata, 1 pops the front entry. Each request gives exactly one m_ word:
// m_tuser is the status, m_tdata the popped priority and tag (zero unless a
// pop succeeded) and the occupancy after the request.
// cfg_valid/cfg_data set the capacity, clamped to 1..64; write only while idle.
// A pop or a refused request is decided, then its result is loaded in the
// respond state. An insert walks back from the tail, one memory read and
// one shifted entry per cycle, past the k held entries of lower priority
// than the new one (at most 63); it then places the new entry and responds.
// One request is in work at a time; the next one is taken as soon as its
// result sits in the output register, even if that word is not yet taken.
// A stalled receiver holds the result; a further result then waits in the
// controller and s_tready stays low.
// Reset empties the queue and sets the capacity to 64; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core
    import spq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [39:0]          s_tdata,   // new_priority, new_tag
    input  logic                 s_tuser,   // req_type
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // out_priority, out_tag, occupancy, zero pad
    output logic [1:0]           m_tuser,   // status
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_W-1:0]     cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    spq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    spq_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

    // one request in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in work");

    // occupancy never exceeds the built depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[46:40] <= OCC_W'(DEPTH)))
        else $error("occupancy beyond depth");

    // only a successful pop carries payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != ST_POPPED)) |-> (m_tdata[39:0] == '0))
        else $error("payload on a result that is not a pop");

    // a successful insert leaves at least one entry
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == ST_INSERTED)) |-> (m_tdata[46:40] != '0))
        else $error("insert reported with empty queue");

endmodule

@@ bench/tb_sorted_priority_queue_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// Self-checking bench for the sorted priority queue core. A table of directed
// requests and capacity writes comes first: empty pops, extreme priorities and
// tags, ties, full refusals and capacities 0, 1 and 127. Random bursts follow.
// Each burst fills, drains or mixes the queue, with wide, narrow or extreme
// priorities, and changes the capacity, also below the current occupancy.
// Every result word is checked field by field: directed rows against the
// table, random ones against a sorted software copy of the queue.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
    import spq_pkg::*;

    localparam int RAND_ITEMS   = 1425;
    localparam int DIR_ROWS     = 27;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef struct packed {
        status_t          st;
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
        logic [OCC_W-1:0] occ;
    } resp_t;

    typedef struct {
        bit               is_cfg;
        logic [CFG_W-1:0] cfg_val;
        req_t             kind;
        logic [PRI_W-1:0] pri;
        logic [TAG_W-1:0] tag;
        bit               typed;
        resp_t            want;
    } dir_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [39:0]      s_tdata   = '0;    // new_priority, new_tag
    logic             s_tuser   = 1'b0;  // req_type
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;           // out_priority, out_tag, occupancy, zero pad
    logic [1:0]       m_tuser;           // status
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;

    entry_t held_entries[$];
    resp_t  due_words[$];
    int     cap_limit      = DEPTH;
    int     mismatch_count = 0;
    int     idle_phase     = 0;

    sorted_priority_queue_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic resp_t serve_request(req_t kind, logic [PRI_W-1:0] pri,
                                            logic [TAG_W-1:0] tag);
        resp_t  r;
        entry_t e;
        int     pos;
        r = '0;
        if (kind == REQ_INSERT) begin
            if (held_entries.size() >= cap_limit) begin
                r.st = ST_FULL;
            end else begin
                pos = 0;
                while (pos < held_entries.size() && held_entries[pos].pri >= pri)
                    pos++;
                e.pri = pri;
                e.tag = tag;
                held_entries.insert(pos, e);
                r.st = ST_INSERTED;
            end
        end else if (held_entries.size() == 0) begin
            r.st = ST_EMPTY;
        end else begin
            e = held_entries.pop_front();
            r.st  = ST_POPPED;
            r.pri = e.pri;
            r.tag = e.tag;
        end
        r.occ = OCC_W'(held_entries.size());
        return r;
    endfunction

    task automatic send_request(req_t kind, logic [PRI_W-1:0] pri, logic [TAG_W-1:0] tag,
                                bit typed, resp_t want);
        int    pct;
        resp_t r;
        pct = (idle_phase == 0) ? 6 : (idle_phase == 1) ? 47 : 0;
        if ($urandom_range(99) < pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {tag, pri};
        do @(posedge aclk); while (!s_tready);
        r = serve_request(kind, pri, tag);
        due_words.push_back(typed ? want : r);
    endtask

    task automatic write_capacity(logic [CFG_W-1:0] v);
        s_tvalid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (v == 0)
            cap_limit = 1;
        else if (v > DEPTH)
            cap_limit = DEPTH;
        else
            cap_limit = int'(v);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin : rx_check
        resp_t want;
        int    pct;
        pct = (idle_phase == 0) ? 47 : (idle_phase == 1) ? 6 : 0;
        m_tready <= ($urandom_range(99) >= pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (due_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, status %0d, data 0x%0h",
                         $time, m_tuser, m_tdata);
            end else begin
                want = due_words.pop_front();
                check_field("status", 32'(want.st), 32'(m_tuser));
                check_field("out_priority", 32'(want.pri), 32'(m_tdata[7:0]));
                check_field("out_tag", want.tag, m_tdata[39:8]);
                check_field("occupancy", 32'(want.occ), 32'(m_tdata[46:40]));
                check_field("pad", 32'(0), 32'(m_tdata[47]));
            end
        end
    end

    initial begin : stimulus
        dir_row_t         rows[DIR_ROWS];
        resp_t            none;
        req_t             kind;
        logic [PRI_W-1:0] pri;
        logic [CFG_W-1:0] cap_val;
        int               seg_left;
        int               seg_no;
        int               ins_pct;
        int               pri_mode;
        rows = '{
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_EMPTY,    8'h00, 32'h00000000, 7'd0}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h00, 32'h00000000, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd1}},
            '{1'b0, 7'd0, REQ_INSERT, 8'hff, 32'hffffffff, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd2}},
            '{1'b0, 7'd0, REQ_INSERT, 8'hff, 32'h00000001, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd3}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h80, 32'ha5a5a5a5, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd4}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h80, 32'h5a5a5a5a, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd5}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h00, 32'h12345678, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd6}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'hff, 32'hffffffff, 7'd5}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'hff, 32'h00000001, 7'd4}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h80, 32'ha5a5a5a5, 7'd3}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h80, 32'h5a5a5a5a, 7'd2}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h01, 32'h0f0f0f0f, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd3}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h01, 32'h0f0f0f0f, 7'd2}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h00, 32'h00000000, 7'd1}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h00, 32'h12345678, 7'd0}},
            // pop fields are don't-care
            '{1'b0, 7'd0, REQ_POP,    8'hff, 32'hffffffff, 1'b1,
              '{ST_EMPTY,    8'h00, 32'h00000000, 7'd0}},
            '{1'b1, 7'd1, REQ_INSERT, 8'h00, 32'h00000000, 1'b0, '0},
            '{1'b0, 7'd0, REQ_INSERT, 8'hc8, 32'h80000001, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd1}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h64, 32'h7ffffffe, 1'b1,
              '{ST_FULL,     8'h00, 32'h00000000, 7'd1}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'hc8, 32'h80000001, 7'd0}},
            // zero capacity acts as one
            '{1'b1, 7'd0, REQ_INSERT, 8'h00, 32'h00000000, 1'b0, '0},
            '{1'b0, 7'd0, REQ_INSERT, 8'h07, 32'h00000077, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd1}},
            '{1'b0, 7'd0, REQ_INSERT, 8'h09, 32'h00000099, 1'b1,
              '{ST_FULL,     8'h00, 32'h00000000, 7'd1}},
            '{1'b1, 7'd127, REQ_INSERT, 8'h00, 32'h00000000, 1'b0, '0},
            '{1'b0, 7'd0, REQ_INSERT, 8'h09, 32'h00000099, 1'b1,
              '{ST_INSERTED, 8'h00, 32'h00000000, 7'd2}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h09, 32'h00000099, 7'd1}},
            '{1'b0, 7'd0, REQ_POP,    8'h00, 32'h00000000, 1'b1,
              '{ST_POPPED,   8'h07, 32'h00000077, 7'd0}}
        };
        none = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].is_cfg)
                write_capacity(rows[i].cfg_val);
            else
                send_request(rows[i].kind, rows[i].pri, rows[i].tag, rows[i].typed,
                             rows[i].want);
        end

        seg_left = 0;
        seg_no   = 0;
        ins_pct  = 50;
        pri_mode = 0;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            idle_phase = n * 3 / RAND_ITEMS;
            if (seg_left == 0) begin
                case (seg_no)
                    // fill up to the full built depth
                    0: begin
                        cap_val  = 7'd127;
                        ins_pct  = 85;
                        seg_left = 110;
                    end
                    // capacity below current occupancy
                    1: begin
                        cap_val  = 7'd5;
                        ins_pct  = 50;
                        seg_left = 40;
                    end
                    default: begin
                        case ($urandom_range(7))
                            0: cap_val = 7'd0;
                            1: cap_val = 7'd1;
                            2: cap_val = 7'd2;
                            3: cap_val = 7'd64;
                            4: cap_val = 7'd65;
                            5: cap_val = 7'd127;
                            6: cap_val = CFG_W'($urandom_range(3, 16));
                            default: cap_val = CFG_W'($urandom_range(1, 127));
                        endcase
                        case ($urandom_range(2))
                            0: ins_pct = 85;
                            1: ins_pct = 50;
                            default: ins_pct = 20;
                        endcase
                        seg_left = $urandom_range(30, 110);
                    end
                endcase
                pri_mode = $urandom_range(2);
                seg_no++;
                write_capacity(cap_val);
            end
            kind = ($urandom_range(99) < ins_pct) ? REQ_INSERT : REQ_POP;
            case (pri_mode)
                0: pri = PRI_W'($urandom_range(255));
                // few values, lots of ties
                1: pri = PRI_W'(100 + $urandom_range(2));
                default: pri = $urandom_range(1) ? 8'hff : 8'h00;
            endcase
            send_request(kind, pri, $urandom, 1'b0, none);
            seg_left--;
        end

        s_tvalid <= 1'b0;
        while (due_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && due_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
sv/spq_pkg.sv
sv/spq_ctrl.sv
sv/spq_dp.sv
sv/sorted_priority_queue_core.sv
bench/tb_sorted_priority_queue_core.sv
